[rtl/button_debounce_double_press_defines.svh]
// Assertion macros for the button debouncer RTL
`ifndef BUTTON_DEBOUNCE_DOUBLE_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_DOUBLE_PRESS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BDP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bdp_pkg.sv]
// Shared types and constants for the button debouncer
package bdp_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int DEB_W       = 8;
    localparam int WIN_TICKS_W = 12;

    localparam int WINDOW_COUNT_BITS = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ACTIVE_LOW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW_TICKS   = 2'd2;

    localparam logic                   RST_ACTIVE_LOW     = 1'b0;
    localparam logic [DEB_W-1:0]       RST_DEBOUNCE_TICKS = 8'd5;
    localparam logic [WIN_TICKS_W-1:0] RST_WINDOW_TICKS   = 12'd370;

    typedef struct packed {
        logic                   active_low;
        logic [DEB_W-1:0]       debounce_ticks;
        logic [WIN_TICKS_W-1:0] window_ticks;
    } t_cfg;

    typedef struct packed {
        logic press;
        logic second_press;
        logic held;
    } t_res;

endpackage

[rtl/bdp_cfg.sv]
// Configuration register file of the button debouncer
module bdp_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bdp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bdp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output bdp_pkg::t_cfg                   o_cfg
);

    bdp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low     <= bdp_pkg::RST_ACTIVE_LOW;
            r_cfg.debounce_ticks <= bdp_pkg::RST_DEBOUNCE_TICKS;
            r_cfg.window_ticks   <= bdp_pkg::RST_WINDOW_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bdp_pkg::CFG_IDX_ACTIVE_LOW: begin
                    r_cfg.active_low <= i_cfg_data[0];
                end
                bdp_pkg::CFG_IDX_DEBOUNCE_TICKS: begin
                    r_cfg.debounce_ticks <= i_cfg_data[bdp_pkg::DEB_W-1:0];
                end
                bdp_pkg::CFG_IDX_WINDOW_TICKS: begin
                    r_cfg.window_ticks <= i_cfg_data[bdp_pkg::WIN_TICKS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/bdp_core.sv]
// Debounce and second-press state with its per-tick update
module bdp_core #(
    parameter int WINDOW_COUNT_BITS = bdp_pkg::WINDOW_COUNT_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_pin,
    input  bdp_pkg::t_cfg   i_cfg,
    output bdp_pkg::t_res   o_res,
    output logic            o_win_open
);

    localparam int CMP_W = (WINDOW_COUNT_BITS > bdp_pkg::WIN_TICKS_W) ?
                           WINDOW_COUNT_BITS : bdp_pkg::WIN_TICKS_W;
    localparam logic [CMP_W-1:0] WIN_MAX = CMP_W'((1 << WINDOW_COUNT_BITS) - 1);

    logic                         r_stable;
    logic [bdp_pkg::DEB_W-1:0]    r_settle;
    logic [WINDOW_COUNT_BITS-1:0] r_window;

    logic                         n_stable;
    logic [bdp_pkg::DEB_W-1:0]    n_settle;
    logic [WINDOW_COUNT_BITS-1:0] n_window;

    logic                         sample;
    logic                         press;
    logic                         second;
    logic [CMP_W-1:0]             ticks_ext;
    logic [WINDOW_COUNT_BITS-1:0] win_load;

    assign sample    = i_pin ^ i_cfg.active_low;
    assign ticks_ext = CMP_W'(i_cfg.window_ticks);
    assign win_load  = (ticks_ext > WIN_MAX) ? WINDOW_COUNT_BITS'(WIN_MAX)
                                             : WINDOW_COUNT_BITS'(ticks_ext);

    always_comb begin
        n_stable = r_stable;
        n_settle = r_settle;
        if (r_settle != '0) begin
            n_settle = r_settle - 1'b1;
            if (n_settle == '0) begin
                n_stable = sample;
            end
        end else if (sample != r_stable) begin
            if (i_cfg.debounce_ticks == '0) begin
                n_stable = sample;
            end else begin
                n_settle = i_cfg.debounce_ticks;
            end
        end
    end

    assign press  = !r_stable && n_stable;
    assign second = press && (r_window != '0);

    always_comb begin
        n_window = r_window;
        if (second) begin
            n_window = '0;
        end else if (press) begin
            n_window = win_load;
        end else if (r_window != '0) begin
            n_window = r_window - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b0;
            r_settle <= '0;
            r_window <= '0;
        end else if (i_adv) begin
            r_stable <= n_stable;
            r_settle <= n_settle;
            r_window <= n_window;
        end
    end

    assign o_res.press        = press;
    assign o_res.second_press = second;
    assign o_res.held         = n_stable;
    assign o_win_open         = (r_window != '0);

endmodule

[rtl/button_debounce_double_press.sv]
// Top level of the button debouncer with second-press detection
//
// Input channel: one request per millisecond tick on i_in_valid/o_in_ready,
// carrying the raw pin level i_pin_level. Output channel: one result per
// request on o_out_valid/i_out_ready with o_press, o_second_press and o_held.
// Configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_idx
// (0 polarity, 1 settle length, 2 second-press window); unknown indexes are
// ignored. Write only while no request is in flight.
// A request accepted into the input register updates the core state and is
// written to the result register when it advances, and is offered on the
// output from then on. Throughput: one request per cycle while the receiver
// takes results; a stalled receiver holds back new requests.
// Reset (synchronous, active low) empties both stages, releases the debounced
// state, clears the settle and window counters and loads the register defaults.
// When the receiver stalls, the result register holds; the input register
// still takes one more request, then o_in_ready drops until the result leaves.
`include "button_debounce_double_press_defines.svh"

module button_debounce_double_press #(
    parameter int WINDOW_COUNT_BITS = bdp_pkg::WINDOW_COUNT_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bdp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bdp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_pin_level,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_press,
    output logic                            o_second_press,
    output logic                            o_held
);

    bdp_pkg::t_cfg cfg;
    bdp_pkg::t_res res;
    logic          win_open;

    logic          r_in_valid;
    logic          r_in_pin;
    logic          r_out_valid;
    bdp_pkg::t_res r_out;
    logic          advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    bdp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bdp_core #(
        .WINDOW_COUNT_BITS (WINDOW_COUNT_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (advance),
        .i_pin      (r_in_pin),
        .i_cfg      (cfg),
        .o_res      (res),
        .o_win_open (win_open)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_pin <= i_pin_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_press        = r_out.press;
    assign o_second_press = r_out.second_press;
    assign o_held         = r_out.held;

    `BDP_ASSERT_NOW(a_press_held, i_clk, i_rst_n, o_out_valid && o_press, o_held, "press without held state")
    `BDP_ASSERT_NOW(a_second_is_press, i_clk, i_rst_n, o_out_valid && o_second_press, o_press, "second press without press")
    `BDP_ASSERT_NEXT(a_advance_fills, i_clk, i_rst_n, advance && i_rst_n, o_out_valid, "advanced request lost")
    `BDP_ASSERT_NEXT(a_second_closes, i_clk, i_rst_n, advance && res.second_press, !win_open, "window left open after second press")

endmodule
